### src/sgi_pkg.sv
// Shared types and fixed widths for the segment intersection block.
package sgi_pkg;

  localparam int C_BITS = 16;          // coordinate width
  localparam int DIF_W  = C_BITS + 1;  // coordinate difference
  localparam int PRD_W  = 2 * C_BITS;  // coordinate product
  localparam int PRE_W  = PRD_W + 1;   // line constant x1*y2 - y1*x2
  localparam int D_W    = 2 * DIF_W + 1; // signed cross denominator
  localparam int DMAG_W = D_W - 1;     // denominator magnitude
  localparam int MUL_W  = PRE_W + DIF_W; // numerator partial product
  localparam int NX_W   = MUL_W + 1;   // signed numerator
  localparam int BND_W  = NX_W;        // bound times denominator
  localparam int OUT_W  = 32;          // fixed-point result width

  typedef struct packed {
    logic signed [C_BITS-1:0] a_start_x;
    logic signed [C_BITS-1:0] a_start_y;
    logic signed [C_BITS-1:0] a_end_x;
    logic signed [C_BITS-1:0] a_end_y;
    logic signed [C_BITS-1:0] b_start_x;
    logic signed [C_BITS-1:0] b_start_y;
    logic signed [C_BITS-1:0] b_end_x;
    logic signed [C_BITS-1:0] b_end_y;
  } in_t;

  typedef struct packed {
    logic                    hit;
    logic signed [OUT_W-1:0] cross_x;
    logic signed [OUT_W-1:0] cross_y;
  } out_t;

  // Classified item passed from front to back; numerators already sign-fixed
  typedef struct packed {
    logic                    hit;
    logic signed [NX_W-1:0]  nx;
    logic signed [NX_W-1:0]  ny;
    logic [DMAG_W-1:0]       dmag;
  } mid_t;

endpackage

### src/segment_intersection_top.sv
// Stages: 6 front stages, the middle queue, C_BITS+FRAC_BITS+2 back stages, then the
// result queue; FRAC_BITS defaults to 16.
// Throughput: one transaction per cycle; the front and back pipelines stall as a whole
// when the queue after them is full and their last stage holds a valid item.
// Reset (rst_n low, synchronous) empties both queues and clears all stage valid bits.
// Coordinates are 16-bit; FRAC_BITS sets the divider depth and the fraction width.
module segment_intersection_top
  import sgi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  in_t  in_data,
  output logic out_empty,
  input  logic out_pop,
  output out_t out_data
);

  localparam int MID_W  = $bits(mid_t);
  localparam int RES_W  = $bits(out_t);
  localparam int QDEPTH = 4;

  logic             f_en, f_vld, b_en, b_vld;
  mid_t             f_item, m_item;
  out_t             b_item;
  logic             mid_full, mid_empty, mid_pop, res_full;
  logic [MID_W-1:0] m_raw;
  logic [RES_W-1:0] r_raw;

  // advance front while its tail can drain into the queue
  assign f_en    = !f_vld || !mid_full;
  assign in_full = !f_en;

  sgi_front u_front (
    .clk(clk), .rst_n(rst_n), .en(f_en),
    .in_valid(in_push), .in_item(in_data),
    .out_valid(f_vld), .out_item(f_item)
  );

  sgi_fifo #(.W(MID_W), .DEPTH(QDEPTH)) u_mid_q (
    .clk(clk), .rst_n(rst_n),
    .push(f_vld), .wdata(f_item), .full(mid_full),
    .pop(mid_pop), .rdata(m_raw), .empty(mid_empty)
  );

  assign m_item  = mid_t'(m_raw);
  assign b_en    = !b_vld || !res_full;
  assign mid_pop = b_en;

  sgi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .en(b_en),
    .in_valid(!mid_empty), .in_item(m_item),
    .out_valid(b_vld), .out_item(b_item)
  );

  sgi_fifo #(.W(RES_W), .DEPTH(QDEPTH)) u_res_q (
    .clk(clk), .rst_n(rst_n),
    .push(b_vld), .wdata(b_item), .full(res_full),
    .pop(out_pop), .rdata(r_raw), .empty(out_empty)
  );

  assign out_data = out_t'(r_raw);

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty) else $error("result queue not empty after reset");
  a_no_drop_mid: assert property (@(posedge clk) disable iff (!rst_n)
    f_vld && mid_full |-> !f_en) else $error("front advanced into full queue");
  a_no_drop_res: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld && res_full |-> !b_en) else $error("back advanced into full queue");
`endif

endmodule

### src/sgi_fifo.sv
// Small register queue with count-based full and empty flags.
module sgi_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count past depth");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count missed push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> wr_ptr_r == rd_ptr_r) else $error("empty queue with pointer gap");
`endif

endmodule

### src/sgi_front.sv
// Front pipeline: forms denominator and numerators and runs the bounds test.
module sgi_front
  import sgi_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  in_t  in_item,
  output logic out_valid,
  output mid_t out_item
);

  logic [5:0] vld_r;

  // stage 1
  logic signed [DIF_W-1:0]  s1_dx12_r, s1_dy12_r, s1_dx34_r, s1_dy34_r;
  logic signed [PRD_W-1:0]  s1_p1_r, s1_p2_r, s1_p3_r, s1_p4_r;
  in_t                      s1_c_r;
  // stage 2
  logic signed [DIF_W-1:0]  s2_dx12_r, s2_dy12_r, s2_dx34_r, s2_dy34_r;
  logic signed [D_W-1:0]    s2_d_r;
  logic signed [PRE_W-1:0]  s2_pre_r, s2_post_r;
  in_t                      s2_c_r;
  // stage 3
  logic signed [MUL_W-1:0]  s3_m1_r, s3_m2_r, s3_m3_r, s3_m4_r;
  logic signed [D_W-1:0]    s3_d_r;
  in_t                      s3_c_r;
  // stage 4
  logic signed [NX_W-1:0]   s4_nx_r, s4_ny_r;
  logic [DMAG_W-1:0]        s4_dmag_r;
  logic                     s4_dz_r;
  logic signed [C_BITS-1:0] s4_lo_r [4];
  logic signed [C_BITS-1:0] s4_hi_r [4];
  // stage 5
  logic signed [NX_W-1:0]   s5_nx_r, s5_ny_r;
  logic [DMAG_W-1:0]        s5_dmag_r;
  logic                     s5_dz_r;
  logic signed [BND_W-1:0]  s5_lo_r [4];
  logic signed [BND_W-1:0]  s5_hi_r [4];
  // stage 6
  mid_t                     s6_r;

  logic                     dneg;
  logic signed [C_BITS-1:0] pa [4];
  logic signed [C_BITS-1:0] pb [4];
  logic signed [D_W-1:0]    dpos;
  logic                     hit_c;

  always_comb begin
    pa[0] = s3_c_r.a_start_x; pb[0] = s3_c_r.a_end_x;
    pa[1] = s3_c_r.b_start_x; pb[1] = s3_c_r.b_end_x;
    pa[2] = s3_c_r.a_start_y; pb[2] = s3_c_r.a_end_y;
    pa[3] = s3_c_r.b_start_y; pb[3] = s3_c_r.b_end_y;
  end

  assign dneg = s3_d_r[D_W-1];
  assign dpos = dneg ? -s3_d_r : s3_d_r;

  // x numerator against x bounds (0,1), y numerator against y bounds (2,3)
  assign hit_c = !s5_dz_r
    && (s5_nx_r >= s5_lo_r[0]) && (s5_nx_r <= s5_hi_r[0])
    && (s5_nx_r >= s5_lo_r[1]) && (s5_nx_r <= s5_hi_r[1])
    && (s5_ny_r >= s5_lo_r[2]) && (s5_ny_r <= s5_hi_r[2])
    && (s5_ny_r >= s5_lo_r[3]) && (s5_ny_r <= s5_hi_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx12_r <= DIF_W'(in_item.a_start_x) - DIF_W'(in_item.a_end_x);
      s1_dy12_r <= DIF_W'(in_item.a_start_y) - DIF_W'(in_item.a_end_y);
      s1_dx34_r <= DIF_W'(in_item.b_start_x) - DIF_W'(in_item.b_end_x);
      s1_dy34_r <= DIF_W'(in_item.b_start_y) - DIF_W'(in_item.b_end_y);
      s1_p1_r   <= PRD_W'(in_item.a_start_x) * PRD_W'(in_item.a_end_y);
      s1_p2_r   <= PRD_W'(in_item.a_start_y) * PRD_W'(in_item.a_end_x);
      s1_p3_r   <= PRD_W'(in_item.b_start_x) * PRD_W'(in_item.b_end_y);
      s1_p4_r   <= PRD_W'(in_item.b_start_y) * PRD_W'(in_item.b_end_x);
      s1_c_r    <= in_item;

      s2_dx12_r <= s1_dx12_r;
      s2_dy12_r <= s1_dy12_r;
      s2_dx34_r <= s1_dx34_r;
      s2_dy34_r <= s1_dy34_r;
      s2_d_r    <= D_W'(s1_dx12_r) * D_W'(s1_dy34_r) - D_W'(s1_dy12_r) * D_W'(s1_dx34_r);
      s2_pre_r  <= PRE_W'(s1_p1_r) - PRE_W'(s1_p2_r);
      s2_post_r <= PRE_W'(s1_p3_r) - PRE_W'(s1_p4_r);
      s2_c_r    <= s1_c_r;

      s3_m1_r <= MUL_W'(s2_pre_r) * MUL_W'(s2_dx34_r);
      s3_m2_r <= MUL_W'(s2_dx12_r) * MUL_W'(s2_post_r);
      s3_m3_r <= MUL_W'(s2_pre_r) * MUL_W'(s2_dy34_r);
      s3_m4_r <= MUL_W'(s2_dy12_r) * MUL_W'(s2_post_r);
      s3_d_r  <= s2_d_r;
      s3_c_r  <= s2_c_r;

      // fold the denominator sign into the numerators
      s4_nx_r   <= dneg ? NX_W'(s3_m2_r) - NX_W'(s3_m1_r) : NX_W'(s3_m1_r) - NX_W'(s3_m2_r);
      s4_ny_r   <= dneg ? NX_W'(s3_m4_r) - NX_W'(s3_m3_r) : NX_W'(s3_m3_r) - NX_W'(s3_m4_r);
      s4_dmag_r <= dpos[DMAG_W-1:0];
      s4_dz_r   <= (s3_d_r == '0);
      for (int i = 0; i < 4; i++) begin
        s4_lo_r[i] <= (pa[i] < pb[i]) ? pa[i] : pb[i];
        s4_hi_r[i] <= (pa[i] < pb[i]) ? pb[i] : pa[i];
      end

      s5_nx_r   <= s4_nx_r;
      s5_ny_r   <= s4_ny_r;
      s5_dmag_r <= s4_dmag_r;
      s5_dz_r   <= s4_dz_r;
      for (int i = 0; i < 4; i++) begin
        s5_lo_r[i] <= BND_W'(s4_lo_r[i]) * BND_W'($signed({1'b0, s4_dmag_r}));
        s5_hi_r[i] <= BND_W'(s4_hi_r[i]) * BND_W'($signed({1'b0, s4_dmag_r}));
      end

      s6_r.hit  <= hit_c;
      s6_r.nx   <= s5_nx_r;
      s6_r.ny   <= s5_ny_r;
      s6_r.dmag <= s5_dmag_r;
    end
  end

  assign out_valid = vld_r[5];
  assign out_item  = s6_r;

endmodule

### src/sgi_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module sgi_div #(
  parameter int NW = 67,
  parameter int DW = 34,
  parameter int QB = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QB-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic [NW-1:0] num_r  [QB];
  logic [DW-1:0] den_r  [QB];
  logic [QB-1:0] quo_r  [QB];
  logic [SW-1:0] side_r [QB];
  logic [QB-1:0] vld_r;

  logic [NW-1:0] n_in  [QB];
  logic [DW-1:0] d_in  [QB];
  logic [QB-1:0] q_in  [QB];
  logic [SW-1:0] s_in  [QB];
  logic [QB-1:0] v_in;
  logic [NW:0]   trial [QB];

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      if (k == 0) begin
        n_in[k] = in_num;
        d_in[k] = in_den;
        q_in[k] = '0;
        s_in[k] = in_side;
        v_in[k] = in_valid;
      end else begin
        n_in[k] = num_r[k-1];
        d_in[k] = den_r[k-1];
        q_in[k] = quo_r[k-1];
        s_in[k] = side_r[k-1];
        v_in[k] = vld_r[k-1];
      end
      // stage k settles quotient bit QB-1-k
      trial[k] = {1'b0, n_in[k]} - {1'b0, NW'(d_in[k]) << (QB - 1 - k)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QB; k++) begin
        num_r[k]  <= trial[k][NW] ? n_in[k] : trial[k][NW-1:0];
        quo_r[k]  <= {q_in[k][QB-2:0], ~trial[k][NW]};
        den_r[k]  <= d_in[k];
        side_r[k] <= s_in[k];
      end
    end
  end

  assign out_valid = vld_r[QB-1];
  assign out_quo   = quo_r[QB-1];
  assign out_side  = side_r[QB-1];

endmodule

### src/sgi_back.sv
// Back pipeline: divides the numerators into Q format and builds the result.
module sgi_back
  import sgi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  mid_t in_item,
  output logic out_valid,
  output out_t out_item
);

  localparam int NW = NX_W + FRAC_BITS;
  localparam int QB = C_BITS + FRAC_BITS;
  localparam int QW = (QB > OUT_W) ? QB : OUT_W;

  logic              p_vld_r;
  logic [NW-1:0]     p_nx_r, p_ny_r;
  logic [DMAG_W-1:0] p_d_r;
  logic              p_hit_r, p_negx_r, p_negy_r;
  logic [NX_W-1:0]   magx, magy;

  logic              dx_vld, dy_vld;
  logic [QB-1:0]     qx, qy;
  logic [1:0]        sx;
  logic              sy;
  logic [QW-1:0]     xz, yz, xr, yr;

  logic              f_vld_r;
  out_t              f_r;

  assign magx = in_item.nx[NX_W-1] ? NX_W'(-in_item.nx) : NX_W'(in_item.nx);
  assign magy = in_item.ny[NX_W-1] ? NX_W'(-in_item.ny) : NX_W'(in_item.ny);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= in_valid;
      f_vld_r <= dx_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_nx_r   <= NW'(magx) << FRAC_BITS;
      p_ny_r   <= NW'(magy) << FRAC_BITS;
      p_d_r    <= in_item.dmag;
      p_hit_r  <= in_item.hit;
      p_negx_r <= in_item.nx[NX_W-1];
      p_negy_r <= in_item.ny[NX_W-1];
    end
  end

  sgi_div #(.NW(NW), .DW(DMAG_W), .QB(QB), .SW(2)) u_div_x (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(p_vld_r), .in_num(p_nx_r), .in_den(p_d_r),
    .in_side({p_hit_r, p_negx_r}),
    .out_valid(dx_vld), .out_quo(qx), .out_side(sx)
  );

  sgi_div #(.NW(NW), .DW(DMAG_W), .QB(QB), .SW(1)) u_div_y (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(p_vld_r), .in_num(p_ny_r), .in_den(p_d_r),
    .in_side(p_negy_r),
    .out_valid(dy_vld), .out_quo(qy), .out_side(sy)
  );

  assign xz = QW'(qx);
  assign yz = QW'(qy);
  assign xr = sx[0] ? QW'(0) - xz : xz;
  assign yr = sy ? QW'(0) - yz : yz;

  always_ff @(posedge clk) begin
    if (en) begin
      f_r.hit     <= sx[1];
      f_r.cross_x <= sx[1] ? $signed(xr[OUT_W-1:0]) : '0;
      f_r.cross_y <= sx[1] ? $signed(yr[OUT_W-1:0]) : '0;
    end
  end

  assign out_valid = f_vld_r;
  assign out_item  = f_r;

`ifndef SYNTHESIS
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    dx_vld == dy_vld) else $error("divider lanes out of step");
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(f_vld_r)) else $error("tail moved while stalled");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    f_vld_r && !f_r.hit |-> f_r.cross_x == '0 && f_r.cross_y == '0)
    else $error("miss with nonzero point");
`endif

endmodule

### tb/segment_intersection_top_tb.sv
// Testbench for segment_intersection_top: queue handshakes checked against an exact predictor.
module segment_intersection_top_tb;
  import sgi_pkg::*;

  localparam int FRAC = 16;

  logic clk = 0;
  logic rst_n = 0;
  logic in_push = 0;
  logic in_full;
  in_t  in_data = '0;
  logic out_empty;
  logic out_pop = 0;
  out_t out_data;

  out_t expected_q[$];
  int   fail_cnt = 0;
  int   hit_cnt = 0;
  int   sent_cnt = 0;
  int   send_idle_pct = 0;
  int   pop_stall_pct = 0;

  always #5 clk = ~clk;

  segment_intersection_top #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  // Truncated quotient of num * 2^FRAC / den, den > 0, low 32 bits
  function automatic logic [31:0] fixed_quot(logic signed [127:0] num, logic signed [127:0] den);
    logic signed [127:0] mag;
    logic signed [127:0] q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< FRAC) / den;
    if (num < 0) q = -q;
    return q[31:0];
  endfunction

  function automatic bit in_bounds(logic signed [127:0] n, logic signed [127:0] p,
                                   logic signed [127:0] q, logic signed [127:0] d);
    logic signed [127:0] lo;
    logic signed [127:0] hi;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    return (n >= lo * d) && (n <= hi * d);
  endfunction

  function automatic out_t predict_cross(in_t s);
    logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
    logic signed [127:0] d, pre, post, nx, ny;
    out_t r;
    x1 = 128'(s.a_start_x); y1 = 128'(s.a_start_y);
    x2 = 128'(s.a_end_x);   y2 = 128'(s.a_end_y);
    x3 = 128'(s.b_start_x); y3 = 128'(s.b_start_y);
    x4 = 128'(s.b_end_x);   y4 = 128'(s.b_end_y);
    r = '0;
    d = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
    if (d == 0) return r;
    pre = x1 * y2 - y1 * x2;
    post = x3 * y4 - y3 * x4;
    nx = pre * (x3 - x4) - (x1 - x2) * post;
    ny = pre * (y3 - y4) - (y1 - y2) * post;
    if (d < 0) begin
      d = -d; nx = -nx; ny = -ny;
    end
    if (!in_bounds(nx, x1, x2, d) || !in_bounds(nx, x3, x4, d) ||
        !in_bounds(ny, y1, y2, d) || !in_bounds(ny, y3, y4, d)) return r;
    r.hit = 1'b1;
    r.cross_x = fixed_quot(nx, d);
    r.cross_y = fixed_quot(ny, d);
    return r;
  endfunction

  // Leave push high on return; the next send or drain decides it
  task automatic send_segments(in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_full) @(posedge clk);
    expected_q.push_back(predict_cross(s));
    if (predict_cross(s).hit) hit_cnt++;
    sent_cnt++;
  endtask

  // Check each popped transaction against the oldest prediction
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %p", out_data);
        fail_cnt++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_data.hit !== exp_r.hit) begin
          $error("hit: expected %0d actual %0d", exp_r.hit, out_data.hit);
          fail_cnt++;
        end
        if (out_data.cross_x !== exp_r.cross_x) begin
          $error("cross_x: expected %0d actual %0d", exp_r.cross_x, out_data.cross_x);
          fail_cnt++;
        end
        if (out_data.cross_y !== exp_r.cross_y) begin
          $error("cross_y: expected %0d actual %0d", exp_r.cross_y, out_data.cross_y);
          fail_cnt++;
        end
      end
    end
    out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  function automatic in_t pack_pts(int ax, int ay, int bx, int by,
                                   int cx, int cy, int ex, int ey);
    in_t s;
    s.a_start_x = C_BITS'(ax); s.a_start_y = C_BITS'(ay);
    s.a_end_x   = C_BITS'(bx); s.a_end_y   = C_BITS'(by);
    s.b_start_x = C_BITS'(cx); s.b_start_y = C_BITS'(cy);
    s.b_end_x   = C_BITS'(ex); s.b_end_y   = C_BITS'(ey);
    return s;
  endfunction

  task automatic test_directed();
    send_segments(pack_pts(0, 0, 10, 10, 0, 10, 10, 0));
    send_segments(pack_pts(0, 0, 10, 0, 0, 5, 10, 5));              // parallel
    send_segments(pack_pts(0, 0, 10, 0, 2, 0, 8, 0));               // collinear
    send_segments(pack_pts(3, 3, 3, 3, 0, 0, 9, 9));                // single point
    send_segments(pack_pts(0, 0, 10, 0, 10, -5, 10, 5));            // on range end
    send_segments(pack_pts(0, 0, 10, 0, 11, -5, 11, 5));            // just outside
    send_segments(pack_pts(0, 0, 3, 1, 1, 2, 2, -7));               // fractional
    send_segments(pack_pts(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_segments(pack_pts(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
    send_segments(pack_pts(32767, 32767, -32768, -32767, -32768, 32767, 32767, -32768));
    send_segments(pack_pts(-1, -1, -32768, -32768, -32768, -1, -1, -32768));
    send_segments(pack_pts(-32768, -32768, -32768, 32767, -32768, 0, 32767, 0));
    send_segments(pack_pts(0, 0, 0, 0, 0, 0, 0, 0));
    send_segments(pack_pts(-1, -1, -1, -1, -1, -1, -1, -1));
    send_segments(pack_pts(1, 0, -2, 1, 0, -1, -1, 3));
  endtask

  function automatic int pick_coord(int span);
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 32767 : -32768;
    return int'($signed(16'($urandom_range(2 * span) - span)));
  endfunction

  task automatic test_random(int count);
    in_t s;
    int span;
    repeat (count) begin
      span = ($urandom_range(3) == 0) ? 32767 : ($urandom_range(1) ? 100 : 8);
      s = pack_pts(pick_coord(span), pick_coord(span), pick_coord(span), pick_coord(span),
                   pick_coord(span), pick_coord(span), pick_coord(span), pick_coord(span));
      if ($urandom_range(9) == 0) s = in_t'({$urandom, $urandom, $urandom, $urandom});
      send_segments(s);
    end
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_phases();
    send_idle_pct = 0;  pop_stall_pct = 0;  test_random(420);
    send_idle_pct = 54; pop_stall_pct = 0;  test_random(420);
    drain_results();    // sender holds off until the queue is empty
    send_idle_pct = 0;  pop_stall_pct = 54; test_random(420);
    send_idle_pct = 10; pop_stall_pct = 10; test_random(420);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_phases();
    drain_results();
    repeat (60) @(posedge clk);
    $display("Sent %0d segment pairs (%0d hits) through four idle/stall phases.",
             sent_cnt, hit_cnt);
    if (fail_cnt == 0 && expected_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
src/sgi_pkg.sv
src/sgi_fifo.sv
src/sgi_front.sv
src/sgi_div.sv
src/sgi_back.sv
src/segment_intersection_top.sv
tb/segment_intersection_top_tb.sv
